// ===== sv/gsa_pkg.sv =====
// ----------------------------------------------------------------------------
// gsa_pkg - shared types, constants and table functions of the gas alarm
// Item layouts, command and status bundles, curve constants and the
// elaboration-time builders for the log2 and exp2 interpolation tables.
// ----------------------------------------------------------------------------
package gsa_pkg;

    localparam int ADC_BITS_DEF    = 12;
    localparam int TABLE_DEPTH_DEF = 64;

    localparam int DATA_W    = 24;
    localparam int TIME_W    = 32;
    localparam int SAMPLE_W  = 12;
    localparam int CFG_IDX_W = 8;
    localparam int DIV_W     = 48;
    localparam int RS_W      = 30;

    localparam logic [DATA_W-1:0] PPM_MAX    = 24'hFFFFFF;
    localparam logic [RS_W-1:0]   HIGH_RS    = 30'd255999744;
    localparam logic [DATA_W-1:0] R0_MIN     = 24'd26;
    localparam logic [TIME_W-1:0] WARN_MS    = 32'd500;
    localparam logic [TIME_W-1:0] DANGER_MS  = 32'd200;

    localparam logic [DATA_W-1:0] RESET_BASE   = 24'd2560;
    localparam logic [DATA_W-1:0] RESET_LOAD   = 24'd1280;
    localparam logic [DATA_W-1:0] RESET_WARN   = 24'd300;
    localparam logic [DATA_W-1:0] RESET_DANGER = 24'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_RES   = 8'd0,
        REG_LOAD_RES   = 8'd1,
        REG_WARN_PPM   = 8'd2,
        REG_DANGER_PPM = 8'd3
    } t_reg_idx;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_TICK   = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        LVL_NORMAL  = 2'd0,
        LVL_WARNING = 2'd1,
        LVL_DANGER  = 2'd2
    } t_level;

    typedef enum logic [1:0] {
        CURVE_GAS   = 2'd0,
        CURVE_SMOKE = 2'd1,
        CURVE_LPG   = 2'd2
    } t_curve;

    typedef enum logic {
        DIV_SEL_RS    = 1'b0,
        DIV_SEL_RATIO = 1'b1
    } t_div_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RS_GO,
        ST_RS_WAIT,
        ST_RAT_GO,
        ST_RAT_WAIT,
        ST_LOG,
        ST_MUL_B,
        ST_EXP,
        ST_MUL_A,
        ST_SHIFT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                command;
        logic [SAMPLE_W-1:0] adc_sample;
        logic [TIME_W-1:0]   current_time;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] gas_ppm;
        logic [DATA_W-1:0] smoke_ppm;
        logic [DATA_W-1:0] lpg_ppm;
        logic [1:0]        alert_level;
        logic              alarm_led;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [DATA_W-1:0]    value;
    } t_cfg_item;

    typedef struct packed {
        logic     load_item;
        logic     div_start;
        t_div_sel div_sel;
        logic     capture_rs;
        logic     capture_ratio;
        logic     log_step;
        logic     mulb_step;
        logic     exp_step;
        logic     mula_step;
        logic     shift_step;
        t_curve   curve;
        logic     finish;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic div_done;
        logic out_free;
    } t_stat;

    // curve scale a, q.8
    function automatic logic [17:0] curve_a(input t_curve c);
        case (c)
            CURVE_GAS:   return 18'd168527;
            CURVE_SMOKE: return 18'd198799;
            default:     return 18'd151519;
        endcase
    endfunction

    // curve exponent b, signed q.16
    function automatic logic signed [18:0] curve_b(input t_curve c);
        case (c)
            CURVE_GAS:   return -19'sd135660;
            CURVE_SMOKE: return -19'sd146145;
            default:     return -19'sd127795;
        endcase
    endfunction

    // address bits of the tables: floor(log2(depth)), at most ten
    function automatic int tab_bits(input int depth);
        int t;
        t = 0;
        for (int j = 0; j < 10; j++) begin
            if (t < 10 && (2 << t) <= depth) begin
                t = t + 1;
            end
        end
        return t;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = v;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (b > x) begin
                b = b >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (b != 64'd0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // log2(1 + i/n) in q.16 by repeated squaring in q.30
    function automatic logic [17:0] log_entry(input int i, input int k);
        logic [63:0] x;
        logic [31:0] r;
        x = 64'd0;
        r = 32'd0;
        if (i >= (1 << k)) begin
            return 18'd65536;
        end
        x = 64'((1 << k) + i) << (30 - k);
        for (int j = 0; j < 20; j++) begin
            x = (x * x) >> 30;
            r = r << 1;
            if (x >= (64'd2 << 30)) begin
                x = x >> 1;
                r = r | 32'd1;
            end
        end
        return 18'((r + 32'd8) >> 4);
    endfunction

    // 2^(i/n) in q.16 from a chain of square roots of two
    function automatic logic [17:0] exp_entry(input int i, input int k);
        logic [63:0] roots [1:10];
        logic [63:0] p;
        for (int m = 1; m <= 10; m++) begin
            roots[m] = 64'd0;
        end
        p = 64'd1 << 30;
        if (i >= (1 << k)) begin
            return 18'd131072;
        end
        roots[1] = isqrt64(64'd1 << 61);
        for (int m = 2; m <= 10; m++) begin
            if (m <= k) begin
                roots[m] = isqrt64(roots[m-1] << 30);
            end
        end
        for (int j = 0; j < 10; j++) begin
            if (j < k && ((i >> j) & 1) == 1) begin
                p = (p * roots[k-j]) >> 30;
            end
        end
        return 18'((p + 64'd8192) >> 14);
    endfunction

endpackage

// ===== sv/gsa_stream_if.sv =====
// ----------------------------------------------------------------------------
// gsa_stream_if - valid/ready channel
// Carries one payload item per handshake between a source and a sink.
// ----------------------------------------------------------------------------
interface gsa_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/gas_sensor_ppm_alarm_unit.sv =====
// ----------------------------------------------------------------------------
// gas_sensor_ppm_alarm_unit - gas concentration and alarm led block
// Turns converter samples into sensor resistance, resistance ratio and three
// power-law concentrations, grades the gas level and blinks the alarm led.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                       accepted when
//  i_in     in   command, adc_sample, current_time             valid && ready
//  o_out    out  gas/smoke/lpg ppm, alert_level, alarm_led     valid && ready
//  i_cfg    in   index, value (24 bit register data)           valid && ready
//
// a sample item runs the shared bit-serial divider twice (48 steps each, for
//   rs and for rs/r0), then the log, mul-b, exp, mul-a and shift steps for each curve
// a tick item skips the divisions and curves; one item is worked on at a time
// a finished result sits in the output register, so the next item is taken
//   while it waits; the block stalls only when a second result is ready
// synchronous active-low reset restores the default registers, level normal,
//   led off; the config channel is always ready
//
module gas_sensor_ppm_alarm_unit #(
    parameter int ADC_BITS    = gsa_pkg::ADC_BITS_DEF,
    parameter int TABLE_DEPTH = gsa_pkg::TABLE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gsa_stream_if.sink   i_in,
    gsa_stream_if.source o_out,
    gsa_stream_if.sink   i_cfg
);
    // command and status between sequencer and datapath
    gsa_pkg::t_cmd  w_cmd;
    gsa_pkg::t_stat w_stat;
    logic           w_in_ready;

    gsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    gsa_datapath #(
        .ADC_BITS    (ADC_BITS),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (i_in.data),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (o_out.data)
    );

    // input handshake comes from the sequencer idle state
    assign i_in.ready  = w_in_ready;
    // config writes go straight into the registers
    assign i_cfg.ready = 1'b1;
endmodule

// ===== sv/gsa_div.sv =====
// ----------------------------------------------------------------------------
// gsa_div - shared restoring divider
// One quotient bit per cycle; done is a one-cycle pulse, registered with the last step.
// ----------------------------------------------------------------------------
module gsa_div #(
    parameter int DIVIDEND_W = gsa_pkg::DIV_W,
    parameter int DIVISOR_W  = gsa_pkg::DATA_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_divisor;

    logic [DIVISOR_W:0]    w_trial;
    logic                  w_bit;
    logic [DIVISOR_W-1:0]  n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
        w_bit   = (w_trial >= {1'b0, r_divisor});
        if (w_bit) begin
            n_rem = DIVISOR_W'(w_trial - {1'b0, r_divisor});
        end else begin
            n_rem = w_trial[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo     <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_bit};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// ===== sv/gsa_datapath.sv =====
// ----------------------------------------------------------------------------
// gsa_datapath - resistance, ratio, power curves, level and led
// Config registers, shared divider, log/exp interpolation units, the alarm
// state and the output register.
// ----------------------------------------------------------------------------
module gsa_datapath #(
    parameter int ADC_BITS    = gsa_pkg::ADC_BITS_DEF,
    parameter int TABLE_DEPTH = gsa_pkg::TABLE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gsa_pkg::t_cmd       i_cmd,
    output gsa_pkg::t_stat      o_stat,
    input  gsa_pkg::t_in_item   i_in_data,
    input  logic                i_cfg_valid,
    input  gsa_pkg::t_cfg_item  i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gsa_pkg::t_out_item  o_out_data
);
    localparam int FS    = 1 << ADC_BITS;
    localparam int K     = gsa_pkg::tab_bits(TABLE_DEPTH);
    localparam int N     = 1 << K;
    localparam int SH_L  = 23 - K;
    localparam int SH_E  = 16 - K;
    localparam int MUL_W = ADC_BITS + 6;
    localparam int LP_W  = 17 + SH_L;
    localparam int EP_W  = 18 + SH_E;

    // interpolation tables, built at elaboration
    logic [16:0] w_lt [0:N];
    logic [17:0] w_et [0:N];

    for (genvar gi = 0; gi <= N; gi++) begin : g_tab
        localparam logic [16:0] LT_V = 17'(gsa_pkg::log_entry(gi, K));
        localparam logic [17:0] ET_V = gsa_pkg::exp_entry(gi, K);
        assign w_lt[gi] = LT_V;
        assign w_et[gi] = ET_V;
    end

    logic [gsa_pkg::DATA_W-1:0] r_base;
    logic [gsa_pkg::DATA_W-1:0] r_load;
    logic [gsa_pkg::DATA_W-1:0] r_warn;
    logic [gsa_pkg::DATA_W-1:0] r_danger;

    gsa_pkg::t_command          r_cmd;
    logic [ADC_BITS-1:0]        r_code;
    logic [gsa_pkg::TIME_W-1:0] r_time;
    logic [gsa_pkg::RS_W-1:0]   r_rs;
    logic [gsa_pkg::DATA_W-1:0] r_ratio;

    logic [4:0]                 r_msb;
    logic [16:0]                r_lt_lo;
    logic [LP_W-1:0]            r_lt_prod;
    logic signed [40:0]         r_y;
    logic signed [8:0]          r_ei;
    logic [17:0]                r_et_lo;
    logic [EP_W-1:0]            r_et_prod;
    logic [35:0]                r_val;

    logic [gsa_pkg::DATA_W-1:0] r_gas;
    logic [gsa_pkg::DATA_W-1:0] r_smoke;
    logic [gsa_pkg::DATA_W-1:0] r_lpg;

    gsa_pkg::t_level            r_level;
    logic [gsa_pkg::TIME_W-1:0] r_last;
    logic                       r_led;
    logic                       r_out_valid;
    gsa_pkg::t_out_item         r_out;

    gsa_pkg::t_level            n_level;
    logic [gsa_pkg::TIME_W-1:0] n_last;
    logic                       n_led;

    // divider operands
    logic [ADC_BITS:0]            w_fs_minus;
    logic [gsa_pkg::DIV_W-1:0]    w_dividend;
    logic [gsa_pkg::DATA_W-1:0]   w_divisor;
    logic                         w_div_done;
    logic [gsa_pkg::DIV_W-1:0]    w_quo;
    logic [MUL_W-1:0]             w_code33;
    logic                         w_rs_zero;
    logic                         w_rs_high;

    assign w_fs_minus = (ADC_BITS+1)'(FS) - {1'b0, r_code};
    assign w_dividend = (i_cmd.div_sel == gsa_pkg::DIV_SEL_RS) ?
                        gsa_pkg::DIV_W'(r_load) * gsa_pkg::DIV_W'(w_fs_minus) :
                        gsa_pkg::DIV_W'({r_rs, 16'd0});
    assign w_divisor  = (i_cmd.div_sel == gsa_pkg::DIV_SEL_RS) ?
                        gsa_pkg::DATA_W'(r_code) : r_base;
    assign w_code33   = MUL_W'(r_code) * MUL_W'(33);
    assign w_rs_zero  = &r_code;
    assign w_rs_high  = (w_code33 < MUL_W'(FS));

    gsa_div #(
        .DIVIDEND_W (gsa_pkg::DIV_W),
        .DIVISOR_W  (gsa_pkg::DATA_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // log2 of the ratio
    logic [4:0]        w_msb;
    logic [23:0]       w_norm;
    logic [K-1:0]      w_lidx;
    logic [SH_L-1:0]   w_lrem;
    logic [16:0]       w_lt_a;
    logic [16:0]       w_lt_b;

    always_comb begin
        w_msb = 5'd0;
        for (int j = 0; j < 24; j++) begin
            if (r_ratio[j]) begin
                w_msb = 5'(j);
            end
        end
    end

    assign w_norm = r_ratio << (5'd23 - w_msb);
    assign w_lidx = w_norm[22 -: K];
    assign w_lrem = w_norm[SH_L-1:0];
    assign w_lt_a = w_lt[(K+1)'(w_lidx)];
    assign w_lt_b = w_lt[(K+1)'(w_lidx) + (K+1)'(1)];

    logic [16:0]        w_lf;
    logic signed [5:0]  w_lg_int;
    logic signed [21:0] w_lg;

    assign w_lf     = r_lt_lo + 17'(r_lt_prod >> SH_L);
    assign w_lg_int = 6'({1'b0, r_msb}) - 6'd16;
    assign w_lg     = $signed({w_lg_int, 16'd0}) + $signed({5'd0, w_lf});

    // exponent split and exp2 lookup
    logic signed [40:0] w_t;
    logic [15:0]        w_ef;
    logic [K-1:0]       w_eidx;
    logic [SH_E-1:0]    w_erem;
    logic [17:0]        w_et_a;
    logic [17:0]        w_et_b;
    logic [17:0]        w_ex;

    assign w_t    = r_y + 41'sd32768;
    assign w_ef   = w_t[31:16];
    assign w_eidx = w_ef[15 -: K];
    assign w_erem = w_ef[SH_E-1:0];
    assign w_et_a = w_et[(K+1)'(w_eidx)];
    assign w_et_b = w_et[(K+1)'(w_eidx) + (K+1)'(1)];
    assign w_ex   = r_et_lo + 18'(r_et_prod >> SH_E);

    // final scale by 2^(int part - 24) with saturation
    logic signed [9:0]          w_s;
    logic [9:0]                 w_amt;
    logic [35:0]                w_shr;
    logic [gsa_pkg::DATA_W-1:0] w_ppm;

    always_comb begin
        w_s   = 10'(r_ei) - 10'sd24;
        w_amt = 10'(-w_s);
        w_shr = r_val >> w_amt[5:0];
        if (r_ratio == '0) begin
            w_ppm = '0;
        end else if (w_s >= 10'sd0) begin
            w_ppm = gsa_pkg::PPM_MAX;
        end else if (w_amt >= 10'd36) begin
            w_ppm = '0;
        end else if (|w_shr[35:24]) begin
            w_ppm = gsa_pkg::PPM_MAX;
        end else begin
            w_ppm = w_shr[23:0];
        end
    end

    // level and led for the finishing item
    logic [gsa_pkg::TIME_W-1:0] w_gap;

    always_comb begin
        n_level = r_level;
        n_led   = r_led;
        n_last  = r_last;
        w_gap   = r_time - r_last;
        if (r_cmd == gsa_pkg::CMD_SAMPLE) begin
            if (r_gas >= r_danger) begin
                n_level = gsa_pkg::LVL_DANGER;
            end else if (r_gas >= r_warn) begin
                n_level = gsa_pkg::LVL_WARNING;
            end else begin
                n_level = gsa_pkg::LVL_NORMAL;
            end
        end else begin
            case (r_level)
                gsa_pkg::LVL_WARNING: begin
                    if (w_gap >= gsa_pkg::WARN_MS) begin
                        n_led  = ~r_led;
                        n_last = r_time;
                    end
                end
                gsa_pkg::LVL_DANGER: begin
                    if (w_gap >= gsa_pkg::DANGER_MS) begin
                        n_led  = ~r_led;
                        n_last = r_time;
                    end
                end
                default: begin
                    n_led = 1'b0;
                end
            endcase
        end
    end

    // config registers and alarm state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= gsa_pkg::RESET_BASE;
            r_load      <= gsa_pkg::RESET_LOAD;
            r_warn      <= gsa_pkg::RESET_WARN;
            r_danger    <= gsa_pkg::RESET_DANGER;
            r_level     <= gsa_pkg::LVL_NORMAL;
            r_last      <= '0;
            r_led       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_data.index)
                    gsa_pkg::REG_BASE_RES:   r_base   <= i_cfg_data.value;
                    gsa_pkg::REG_LOAD_RES:   r_load   <= i_cfg_data.value;
                    gsa_pkg::REG_WARN_PPM:   r_warn   <= i_cfg_data.value;
                    gsa_pkg::REG_DANGER_PPM: r_danger <= i_cfg_data.value;
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                r_level     <= n_level;
                r_led       <= n_led;
                r_last      <= n_last;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd  <= gsa_pkg::t_command'(i_in_data.command);
            r_code <= ADC_BITS'(i_in_data.adc_sample);
            r_time <= i_in_data.current_time;
        end
        if (i_cmd.capture_rs) begin
            if (w_rs_zero) begin
                r_rs <= '0;
            end else if (w_rs_high) begin
                r_rs <= gsa_pkg::HIGH_RS;
            end else begin
                r_rs <= w_quo[gsa_pkg::RS_W-1:0];
            end
        end
        if (i_cmd.capture_ratio) begin
            if (r_base < gsa_pkg::R0_MIN) begin
                r_ratio <= '0;
            end else if (|w_quo[gsa_pkg::DIV_W-1:24]) begin
                r_ratio <= gsa_pkg::PPM_MAX;
            end else begin
                r_ratio <= w_quo[23:0];
            end
        end
        if (i_cmd.log_step) begin
            r_msb     <= w_msb;
            r_lt_lo   <= w_lt_a;
            r_lt_prod <= LP_W'(w_lt_b - w_lt_a) * LP_W'(w_lrem);
        end
        if (i_cmd.mulb_step) begin
            r_y <= 41'(gsa_pkg::curve_b(i_cmd.curve)) * 41'(w_lg);
        end
        if (i_cmd.exp_step) begin
            r_ei      <= w_t[40:32];
            r_et_lo   <= w_et_a;
            r_et_prod <= EP_W'(w_et_b - w_et_a) * EP_W'(w_erem);
        end
        if (i_cmd.mula_step) begin
            r_val <= 36'(gsa_pkg::curve_a(i_cmd.curve)) * 36'(w_ex);
        end
        if (i_cmd.shift_step) begin
            case (i_cmd.curve)
                gsa_pkg::CURVE_GAS:   r_gas   <= w_ppm;
                gsa_pkg::CURVE_SMOKE: r_smoke <= w_ppm;
                default:              r_lpg   <= w_ppm;
            endcase
        end
        if (i_cmd.finish) begin
            if (r_cmd == gsa_pkg::CMD_SAMPLE) begin
                r_out.gas_ppm   <= r_gas;
                r_out.smoke_ppm <= r_smoke;
                r_out.lpg_ppm   <= r_lpg;
            end else begin
                r_out.gas_ppm   <= '0;
                r_out.smoke_ppm <= '0;
                r_out.lpg_ppm   <= '0;
            end
            r_out.alert_level <= n_level;
            r_out.alarm_led   <= n_led;
        end
    end

    assign o_stat.is_tick  = (r_cmd == gsa_pkg::CMD_TICK);
    assign o_stat.div_done = w_div_done;
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

`ifndef NO_ASSERTIONS
    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("result not presented after finish");

    a_tick_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && r_cmd == gsa_pkg::CMD_TICK |=>
        r_out.gas_ppm == '0 && r_out.smoke_ppm == '0 && r_out.lpg_ppm == '0)
        else $error("tick result carries nonzero ppm");

    a_normal_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && r_cmd == gsa_pkg::CMD_TICK &&
        r_level == gsa_pkg::LVL_NORMAL |=> !r_led && !r_out.alarm_led)
        else $error("led lit at normal level after tick");
`endif
endmodule

// ===== sv/gsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsa_ctrl - sequencing state machine
// Steps one item through the two divisions, three curves and the finish; a tick item goes straight to the finish.
// ----------------------------------------------------------------------------
module gsa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output gsa_pkg::t_cmd  o_cmd,
    input  gsa_pkg::t_stat i_stat
);
    gsa_pkg::t_state r_state;
    gsa_pkg::t_state n_state;
    gsa_pkg::t_curve r_curve;
    gsa_pkg::t_curve n_curve;

    // next state and curve counter
    always_comb begin
        n_state = r_state;
        n_curve = r_curve;
        case (r_state)
            gsa_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = gsa_pkg::ST_RS_GO;
                end
            end
            gsa_pkg::ST_RS_GO: begin
                n_state = i_stat.is_tick ? gsa_pkg::ST_DONE : gsa_pkg::ST_RS_WAIT;
            end
            gsa_pkg::ST_RS_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = gsa_pkg::ST_RAT_GO;
                end
            end
            gsa_pkg::ST_RAT_GO: begin
                n_state = gsa_pkg::ST_RAT_WAIT;
            end
            gsa_pkg::ST_RAT_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = gsa_pkg::ST_LOG;
                    n_curve = gsa_pkg::CURVE_GAS;
                end
            end
            gsa_pkg::ST_LOG:   n_state = gsa_pkg::ST_MUL_B;
            gsa_pkg::ST_MUL_B: n_state = gsa_pkg::ST_EXP;
            gsa_pkg::ST_EXP:   n_state = gsa_pkg::ST_MUL_A;
            gsa_pkg::ST_MUL_A: n_state = gsa_pkg::ST_SHIFT;
            gsa_pkg::ST_SHIFT: begin
                case (r_curve)
                    gsa_pkg::CURVE_GAS: begin
                        n_curve = gsa_pkg::CURVE_SMOKE;
                        n_state = gsa_pkg::ST_LOG;
                    end
                    gsa_pkg::CURVE_SMOKE: begin
                        n_curve = gsa_pkg::CURVE_LPG;
                        n_state = gsa_pkg::ST_LOG;
                    end
                    default: begin
                        n_state = gsa_pkg::ST_DONE;
                    end
                endcase
            end
            gsa_pkg::ST_DONE: begin
                if (i_stat.out_free) begin
                    n_state = gsa_pkg::ST_IDLE;
                end
            end
            default: n_state = gsa_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = gsa_pkg::DIV_SEL_RS;
        o_cmd.curve   = r_curve;
        o_in_ready    = 1'b0;
        case (r_state)
            gsa_pkg::ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            gsa_pkg::ST_RS_GO: begin
                o_cmd.div_start = !i_stat.is_tick;
            end
            gsa_pkg::ST_RS_WAIT: begin
                o_cmd.capture_rs = i_stat.div_done;
            end
            gsa_pkg::ST_RAT_GO: begin
                o_cmd.div_sel   = gsa_pkg::DIV_SEL_RATIO;
                o_cmd.div_start = 1'b1;
            end
            gsa_pkg::ST_RAT_WAIT: begin
                o_cmd.div_sel       = gsa_pkg::DIV_SEL_RATIO;
                o_cmd.capture_ratio = i_stat.div_done;
            end
            gsa_pkg::ST_LOG:   o_cmd.log_step   = 1'b1;
            gsa_pkg::ST_MUL_B: o_cmd.mulb_step  = 1'b1;
            gsa_pkg::ST_EXP:   o_cmd.exp_step   = 1'b1;
            gsa_pkg::ST_MUL_A: o_cmd.mula_step  = 1'b1;
            gsa_pkg::ST_SHIFT: o_cmd.shift_step = 1'b1;
            gsa_pkg::ST_DONE: begin
                o_cmd.finish = i_stat.out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gsa_pkg::ST_IDLE;
            r_curve <= gsa_pkg::CURVE_GAS;
        end else begin
            r_state <= n_state;
            r_curve <= n_curve;
        end
    end
endmodule
